// File: rtl/core/eac_pkg.sv
// Shared types and constants for the entropy accounting and reseed control block.
// Holds the channel payload structs, operation and result codes and the register map.
// No dependencies.
package eac_pkg;

    localparam int DEF_MAX_SOURCES = 8;

    localparam int EST_W      = 21;
    localparam int CLAIM_W    = 32;
    localparam int LEN_W      = 24;
    localparam int SRC_W      = 3;
    localparam int CNT4_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // Estimates saturate here; the 4 bits per byte cap applies below 2**18 bytes.
    localparam logic [EST_W-1:0] ENTROPY_CEIL  = 21'h100000;
    localparam int               CAP_SHIFT     = 2;
    localparam int               CAP_LEN_BITS  = EST_W - 1 - CAP_SHIFT;

    localparam logic [CNT4_W-1:0] RST_NUM_SOURCES      = 4'd8;
    localparam logic [EST_W-1:0]  RST_FAST_THRESHOLD   = 21'd100;
    localparam logic [EST_W-1:0]  RST_SLOW_THRESHOLD   = 21'd160;
    localparam logic [CNT4_W-1:0] RST_SOURCES_REQUIRED = 4'd2;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_SEED   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_SOURCE = 2'd1,
        STATUS_EMPTY      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RESEED_NONE = 2'd0,
        RESEED_FAST = 2'd1,
        RESEED_SLOW = 2'd2
    } reseed_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SOURCES      = 2'd0,
        CFG_FAST_THRESHOLD   = 2'd1,
        CFG_SLOW_THRESHOLD   = 2'd2,
        CFG_SOURCES_REQUIRED = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        op_t                operation;
        logic [SRC_W-1:0]   source_index;
        logic [CLAIM_W-1:0] claimed_entropy;
        logic [LEN_W-1:0]   sample_length;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic              pool_used;
        reseed_t           reseed_kind;
        logic              is_seeded;
        logic [CNT4_W-1:0] sources_still_needed;
    } out_t;

endpackage

// File: rtl/core/eac_credit.sv
// Credits one sample's claimed entropy to a pool estimate, with the per-byte cap
// and saturation at the entropy ceiling. Pure combinational logic.
// Depends on eac_pkg.
module eac_credit (
    input  logic [eac_pkg::EST_W-1:0]   est,
    input  logic [eac_pkg::CLAIM_W-1:0] claim,
    input  logic [eac_pkg::LEN_W-1:0]   len,
    output logic [eac_pkg::EST_W-1:0]   est_new
);

    logic [eac_pkg::EST_W-1:0] claim_lim;
    logic [eac_pkg::EST_W-1:0] len_cap;
    logic                      short_len;
    logic [eac_pkg::EST_W-1:0] credit;
    logic [eac_pkg::EST_W:0]   sum;

    always_comb begin
        claim_lim = (claim > eac_pkg::CLAIM_W'(eac_pkg::ENTROPY_CEIL))
                  ? eac_pkg::ENTROPY_CEIL : claim[eac_pkg::EST_W-1:0];
        // Four bits per byte; only short samples are capped.
        len_cap   = {1'b0, len[eac_pkg::CAP_LEN_BITS-1:0], {eac_pkg::CAP_SHIFT{1'b0}}};
        short_len = (len[eac_pkg::LEN_W-1:eac_pkg::CAP_LEN_BITS] == '0);
        credit    = (short_len && claim_lim > len_cap) ? len_cap : claim_lim;
        sum       = {1'b0, credit} + {1'b0, est};
        if (est >= eac_pkg::ENTROPY_CEIL) begin
            est_new = est;
        end else if (sum > {1'b0, eac_pkg::ENTROPY_CEIL}) begin
            est_new = eac_pkg::ENTROPY_CEIL;
        end else begin
            est_new = sum[eac_pkg::EST_W-1:0];
        end
    end

endmodule

// File: rtl/core/entropy_accounting_reseed_control.sv
// Top level of the entropy accounting and reseed control block.
// Depends on eac_pkg and eac_credit.
//
// Usage: each input transaction on s_ carries one event, either an entropy sample
// (source, claimed bits, length in bytes) or a seed-file event. Every event yields
// exactly one result transaction on m_ with the status, the pool credited, the
// reseed that is due and how many more sources must reach the slow threshold.
// The cfg_ channel writes the four configuration registers by index; it is always
// ready. The user must see that it is written only while no event is in flight;
// the block does not enforce this. An event sits in an input register while the
// estimate update, threshold compares and source count are worked out, then moves
// into the result register, which drives m_valid; one event is taken every cycle
// while the receiver keeps up. The per-source estimate registers are updated in
// the same cycle as the result register, so the next event already sees them.
// When the receiver stalls, the result register holds and the input register
// still takes one more event; s_ready drops only when both are full.
// Reset clears all estimates, pool pointers, the seeded flag and both stages, and
// loads the default configuration.
module entropy_accounting_reseed_control #(
    parameter int MAX_SOURCES = eac_pkg::DEF_MAX_SOURCES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  eac_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output eac_pkg::out_t                 m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [eac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eac_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_SOURCES + 1);
    localparam int NW = (CW > eac_pkg::CNT4_W) ? CW : eac_pkg::CNT4_W;

    // Configuration
    logic [eac_pkg::CNT4_W-1:0] num_sources_reg;
    logic [eac_pkg::EST_W-1:0]  fast_thr_reg;
    logic [eac_pkg::EST_W-1:0]  slow_thr_reg;
    logic [eac_pkg::CNT4_W-1:0] src_req_reg;

    // Accounting state
    logic [eac_pkg::EST_W-1:0] fast_est_reg  [MAX_SOURCES];
    logic [eac_pkg::EST_W-1:0] slow_est_reg  [MAX_SOURCES];
    logic [eac_pkg::EST_W-1:0] fast_est_next [MAX_SOURCES];
    logic [eac_pkg::EST_W-1:0] slow_est_next [MAX_SOURCES];
    logic [MAX_SOURCES-1:0]    next_pool_reg;
    logic [MAX_SOURCES-1:0]    next_pool_next;
    logic                      seeded_reg;
    logic                      seeded_next;

    // Pipeline stages
    logic          in_valid_reg;
    eac_pkg::in_t  in_data_reg;
    logic          out_valid_reg;
    eac_pkg::out_t out_data_reg;
    eac_pkg::out_t out_data_next;
    logic          fire;

    // Per-event datapath
    logic [MAX_SOURCES-1:0]    hit;
    logic [MAX_SOURCES-1:0]    in_use;
    logic [eac_pkg::EST_W-1:0] sel_fast;
    logic [eac_pkg::EST_W-1:0] sel_slow;
    logic                      sel_np;
    logic                      pool;
    logic [eac_pkg::EST_W-1:0] est_cur;
    logic [eac_pkg::EST_W-1:0] est_new;
    logic                      src_ok;
    logic                      len_zero;
    logic                      sample_go;
    logic                      seed_go;
    logic [CW-1:0]             over_cnt;
    logic [eac_pkg::EST_W-1:0] slow_after;
    logic [eac_pkg::CNT4_W-1:0] needed;
    logic                      fast_hit;
    logic                      slow_hit;
    logic                      clear_fast;
    logic                      clear_slow;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    eac_credit u_credit (
        .est     (est_cur),
        .claim   (in_data_reg.claimed_entropy),
        .len     (in_data_reg.sample_length),
        .est_new (est_new)
    );

    always_comb begin
        sel_fast = '0;
        sel_slow = '0;
        sel_np   = 1'b0;
        for (int i = 0; i < MAX_SOURCES; i++) begin
            hit[i]    = (int'(in_data_reg.source_index) == i);
            in_use[i] = (int'(num_sources_reg) > i);
            if (hit[i]) begin
                sel_fast = sel_fast | fast_est_reg[i];
                sel_slow = sel_slow | slow_est_reg[i];
                sel_np   = sel_np | next_pool_reg[i];
            end
        end
        src_ok    = (int'(in_data_reg.source_index) < int'(num_sources_reg))
                 && (int'(in_data_reg.source_index) < MAX_SOURCES);
        len_zero  = (in_data_reg.sample_length == '0);
        sample_go = (in_data_reg.operation == eac_pkg::OP_SAMPLE) && src_ok && !len_zero;
        seed_go   = (in_data_reg.operation == eac_pkg::OP_SEED) && !len_zero;
        // Before seeding every sample lands in the slow pool.
        pool      = seeded_reg ? sel_np : 1'b1;
        est_cur   = pool ? sel_slow : sel_fast;

        // Count in-use sources at or above the slow threshold, after this update.
        over_cnt = '0;
        for (int i = 0; i < MAX_SOURCES; i++) begin
            slow_after = (sample_go && pool && hit[i]) ? est_new : slow_est_reg[i];
            if (in_use[i] && slow_after >= slow_thr_reg) begin
                over_cnt = over_cnt + CW'(1);
            end
        end
        if (NW'(over_cnt) < NW'(src_req_reg)) begin
            needed = eac_pkg::CNT4_W'(NW'(src_req_reg) - NW'(over_cnt));
        end else begin
            needed = '0;
        end

        fast_hit   = sample_go && !pool && (est_new >= fast_thr_reg);
        slow_hit   = sample_go && pool && (needed == '0);
        clear_fast = seed_go || fast_hit || slow_hit;
        clear_slow = slow_hit;

        for (int i = 0; i < MAX_SOURCES; i++) begin
            fast_est_next[i]  = fast_est_reg[i];
            slow_est_next[i]  = slow_est_reg[i];
            next_pool_next[i] = next_pool_reg[i];
            if (sample_go && hit[i]) begin
                if (pool) begin
                    slow_est_next[i] = est_new;
                end else begin
                    fast_est_next[i] = est_new;
                end
                if (seeded_reg) begin
                    next_pool_next[i] = !next_pool_reg[i];
                end
            end
            if (clear_fast && in_use[i]) begin
                fast_est_next[i] = '0;
            end
            if (clear_slow && in_use[i]) begin
                slow_est_next[i] = '0;
            end
        end
        seeded_next = seeded_reg || clear_fast;

        if (in_data_reg.operation == eac_pkg::OP_SAMPLE && !src_ok) begin
            out_data_next.status = eac_pkg::STATUS_BAD_SOURCE;
        end else if (len_zero) begin
            out_data_next.status = eac_pkg::STATUS_EMPTY;
        end else begin
            out_data_next.status = eac_pkg::STATUS_OK;
        end
        out_data_next.pool_used = sample_go && pool;
        if (slow_hit) begin
            out_data_next.reseed_kind = eac_pkg::RESEED_SLOW;
        end else if (clear_fast) begin
            out_data_next.reseed_kind = eac_pkg::RESEED_FAST;
        end else begin
            out_data_next.reseed_kind = eac_pkg::RESEED_NONE;
        end
        out_data_next.is_seeded            = seeded_next;
        out_data_next.sources_still_needed = needed;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_sources_reg <= eac_pkg::RST_NUM_SOURCES;
            fast_thr_reg    <= eac_pkg::RST_FAST_THRESHOLD;
            slow_thr_reg    <= eac_pkg::RST_SLOW_THRESHOLD;
            src_req_reg     <= eac_pkg::RST_SOURCES_REQUIRED;
        end else if (cfg_valid && cfg_ready) begin
            unique case (eac_pkg::cfg_idx_t'(cfg_index))
                eac_pkg::CFG_NUM_SOURCES: begin
                    num_sources_reg <= cfg_data[eac_pkg::CNT4_W-1:0];
                end
                eac_pkg::CFG_FAST_THRESHOLD: begin
                    fast_thr_reg <= cfg_data[eac_pkg::EST_W-1:0];
                end
                eac_pkg::CFG_SLOW_THRESHOLD: begin
                    slow_thr_reg <= cfg_data[eac_pkg::EST_W-1:0];
                end
                eac_pkg::CFG_SOURCES_REQUIRED: begin
                    src_req_reg <= cfg_data[eac_pkg::CNT4_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Accounting state and pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SOURCES; i++) begin
                fast_est_reg[i] <= '0;
                slow_est_reg[i] <= '0;
            end
            next_pool_reg <= '0;
            seeded_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                for (int i = 0; i < MAX_SOURCES; i++) begin
                    fast_est_reg[i] <= fast_est_next[i];
                    slow_est_reg[i] <= slow_est_next[i];
                end
                next_pool_reg <= next_pool_next;
                seeded_reg    <= seeded_next;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // The input stage stalls only when both stages are full and the receiver waits.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    // Once seeded, the block stays seeded until reset.
    a_seeded_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(seeded_reg))
        else $error("seeded flag dropped");

    // A rejected or empty event never credits a pool or triggers a reseed.
    a_reject_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != eac_pkg::STATUS_OK)
        |-> (!m_data.pool_used && m_data.reseed_kind == eac_pkg::RESEED_NONE))
        else $error("rejected event changed accounting");

    // A fast reseed leaves the first in-use source's fast estimate empty.
    a_fast_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && clear_fast && num_sources_reg != '0) |=> (fast_est_reg[0] == '0))
        else $error("fast estimate not cleared by reseed");

    // A slow reseed also empties the first in-use source's slow estimate.
    a_slow_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && clear_slow && num_sources_reg != '0) |=> (slow_est_reg[0] == '0))
        else $error("slow estimate not cleared by slow reseed");

endmodule

// File: test/eac_result_checker.sv
// Result checker for the entropy accounting and reseed control block.
// Watches the event, result and register channels, predicts every result and compares.
// Depends on eac_pkg.
`timescale 1ns / 1ps

module eac_result_checker
    import eac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_t                  m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           error_count,
    output int unsigned           pending
);

    localparam int SLOTS = DEF_MAX_SOURCES;
    localparam logic [31:0] CEIL32 = 32'(ENTROPY_CEIL);

    logic [CNT4_W-1:0] num_src_q;
    logic [EST_W-1:0]  fast_thr_q;
    logic [EST_W-1:0]  slow_thr_q;
    logic [CNT4_W-1:0] need_q;

    logic [EST_W-1:0]  fast_est [SLOTS];
    logic [EST_W-1:0]  slow_est [SLOTS];
    logic              pool_sel [SLOTS];
    logic              seeded_q;

    out_t expected_results [$];

    function automatic int unsigned live_count();
        return (num_src_q > SLOTS) ? SLOTS : num_src_q;
    endfunction

    // Sources required minus the live sources whose slow estimate reached the threshold.
    function automatic logic [CNT4_W-1:0] shortfall();
        int unsigned k;
        k = 0;
        for (int i = 0; i < live_count(); i++) begin
            if (slow_est[i] >= slow_thr_q) k++;
        end
        return (need_q > k) ? CNT4_W'(need_q - k) : '0;
    endfunction

    task automatic clear_fast_pools();
        for (int i = 0; i < live_count(); i++) fast_est[i] = '0;
        seeded_q = 1'b1;
    endtask

    task automatic clear_slow_pools();
        for (int i = 0; i < live_count(); i++) slow_est[i] = '0;
    endtask

    task automatic account_event(input in_t ev, output out_t res);
        logic [31:0]  credit;
        logic [31:0]  cur;
        logic         pool;
        int unsigned  src;
        res = '0;
        src = ev.source_index;
        if (ev.operation == OP_SEED) begin
            res.sources_still_needed = shortfall();
            if (ev.sample_length == '0) begin
                res.status = STATUS_EMPTY;
            end else begin
                clear_fast_pools();
                res.reseed_kind = RESEED_FAST;
            end
        end else if (src >= live_count()) begin
            res.status = STATUS_BAD_SOURCE;
            res.sources_still_needed = shortfall();
        end else if (ev.sample_length == '0) begin
            res.status = STATUS_EMPTY;
            res.sources_still_needed = shortfall();
        end else begin
            // Unseeded samples always feed the slow pool; afterwards each source alternates.
            pool = seeded_q ? pool_sel[src] : 1'b1;
            if (seeded_q) pool_sel[src] = ~pool_sel[src];
            cur = pool ? 32'(slow_est[src]) : 32'(fast_est[src]);
            if (cur < CEIL32) begin
                credit = (ev.claimed_entropy > CEIL32) ? CEIL32 : ev.claimed_entropy;
                if (32'(ev.sample_length) < (CEIL32 >> 2) &&
                    credit > 32'({ev.sample_length, 2'b00})) begin
                    credit = 32'({ev.sample_length, 2'b00});
                end
                credit = credit + cur;
                if (credit > CEIL32) credit = CEIL32;
                if (pool) slow_est[src] = credit[EST_W-1:0];
                else fast_est[src] = credit[EST_W-1:0];
            end
            res.pool_used = pool;
            res.sources_still_needed = shortfall();
            if (!pool) begin
                if (fast_est[src] >= fast_thr_q) begin
                    clear_fast_pools();
                    res.reseed_kind = RESEED_FAST;
                end
            end else if (res.sources_still_needed == '0) begin
                clear_fast_pools();
                clear_slow_pools();
                res.reseed_kind = RESEED_SLOW;
            end
        end
        res.is_seeded = seeded_q;
    endtask

    always @(posedge aclk) begin
        out_t want;
        out_t got;
        if (!aresetn) begin
            num_src_q  = RST_NUM_SOURCES;
            fast_thr_q = RST_FAST_THRESHOLD;
            slow_thr_q = RST_SLOW_THRESHOLD;
            need_q     = RST_SOURCES_REQUIRED;
            for (int i = 0; i < SLOTS; i++) begin
                fast_est[i] = '0;
                slow_est[i] = '0;
                pool_sel[i] = 1'b0;
            end
            seeded_q = 1'b0;
            expected_results.delete();
            error_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_NUM_SOURCES:      num_src_q  = cfg_data[CNT4_W-1:0];
                    CFG_FAST_THRESHOLD:   fast_thr_q = cfg_data[EST_W-1:0];
                    CFG_SLOW_THRESHOLD:   slow_thr_q = cfg_data[EST_W-1:0];
                    CFG_SOURCES_REQUIRED: need_q     = cfg_data[CNT4_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: %p", got);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.pool_used !== want.pool_used) begin
                        $error("pool_used: expected %0d, got %0d",
                               want.pool_used, got.pool_used);
                        error_count++;
                    end
                    if (got.reseed_kind !== want.reseed_kind) begin
                        $error("reseed_kind: expected %0d, got %0d",
                               want.reseed_kind, got.reseed_kind);
                        error_count++;
                    end
                    if (got.is_seeded !== want.is_seeded) begin
                        $error("is_seeded: expected %0d, got %0d",
                               want.is_seeded, got.is_seeded);
                        error_count++;
                    end
                    if (got.sources_still_needed !== want.sources_still_needed) begin
                        $error("sources_still_needed: expected %0d, got %0d",
                               want.sources_still_needed, got.sources_still_needed);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                account_event(s_data, want);
                expected_results.push_back(want);
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: test/tb_entropy_accounting_reseed_control.sv
// Testbench top for the entropy accounting and reseed control block.
// Drives events, register writes and result back-pressure; eac_result_checker does the checking.
// Depends on eac_pkg, eac_result_checker and the block itself.
`timescale 1ns / 1ps

module tb_entropy_accounting_reseed_control;
    import eac_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned LONG_HOLD   = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned error_count;
    int unsigned pending;
    int unsigned idle_cycles;
    int unsigned calm_left;
    int unsigned live_sources;
    bit          hold_req;

    entropy_accounting_reseed_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    eac_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Ends the run when no transaction of any kind completes for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_entropy_accounting_reseed_control: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [EST_W-1:0] rand_threshold();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return EST_W'($urandom_range(0, 400));
        if (r < 80) return EST_W'($urandom_range(0, ENTROPY_CEIL));
        if (r < 90) return ENTROPY_CEIL;
        return EST_W'($urandom);
    endfunction

    function automatic in_t pack_event(op_t op, logic [SRC_W-1:0] src,
                                       logic [CLAIM_W-1:0] claim, logic [LEN_W-1:0] len);
        in_t ev;
        ev.operation       = op;
        ev.source_index    = src;
        ev.claimed_entropy = claim;
        ev.sample_length   = len;
        return ev;
    endfunction

    function automatic in_t random_event(int unsigned live);
        op_t                op;
        logic [SRC_W-1:0]   src;
        logic [CLAIM_W-1:0] claim;
        logic [LEN_W-1:0]   len;
        int unsigned        r;
        op = ($urandom_range(0, 99) < 4) ? OP_SEED : OP_SAMPLE;
        if (live != 0 && $urandom_range(0, 99) < 85) src = SRC_W'($urandom_range(0, live - 1));
        else src = SRC_W'($urandom_range(0, 7));
        // Lengths cluster around the point where the per-byte cap stops applying.
        r = $urandom_range(0, 99);
        if (r < 5) len = '0;
        else if (r < 40) len = LEN_W'($urandom_range(1, 64));
        else if (r < 55) len = LEN_W'($urandom_range(24'h03FFFE, 24'h040001));
        else if (r < 75) len = LEN_W'($urandom_range(1, 24'h03FFFF));
        else if (r < 80) len = '1;
        else len = LEN_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40) claim = $urandom_range(0, 300);
        else if (r < 55) claim = $urandom_range(32'h000FFFFE, 32'h00100002);
        else if (r < 62) claim = '1;
        else if (r < 70) claim = 32'({len, 2'b00}) + $urandom_range(0, 2) - 1;
        else claim = $urandom;
        return pack_event(op, src, claim, len);
    endfunction

    task automatic send_item(input in_t ev, input bit no_gaps);
        int unsigned gap;
        s_data  <= ev;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (!no_gaps) begin
            if (calm_left != 0) begin
                calm_left--;
            end else if ($urandom_range(0, 19) == 0) begin
                calm_left = $urandom_range(20, 50);
            end else begin
                gap = pick_gap();
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    task automatic drain_results();
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic run_phase(input logic [CNT4_W-1:0] nsrc, input logic [EST_W-1:0] fthr,
                             input logic [EST_W-1:0] sthr, input logic [CNT4_W-1:0] req,
                             input int unsigned items, input bit squeeze);
        int unsigned pause_at;
        drain_results();
        write_reg(CFG_NUM_SOURCES, CFG_DATA_W'(nsrc));
        write_reg(CFG_FAST_THRESHOLD, fthr);
        write_reg(CFG_SLOW_THRESHOLD, sthr);
        write_reg(CFG_SOURCES_REQUIRED, CFG_DATA_W'(req));
        cfg_valid <= 1'b0;
        live_sources = (nsrc > DEF_MAX_SOURCES) ? DEF_MAX_SOURCES : nsrc;
        pause_at = $urandom_range(1, items - 2);
        // The receiver stalls for a long stretch while events keep coming, so the block
        // fills up and has to push back on its input.
        if (squeeze) hold_req = 1'b1;
        for (int unsigned k = 0; k < items; k++) begin
            send_item(random_event(live_sources), squeeze);
            if (k == pause_at) begin
                s_valid <= 1'b0;
                drain_results();
            end
        end
        s_valid <= 1'b0;
    endtask

    // Result side back-pressure: random stalls, full-rate stretches and the long hold.
    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if ($urandom_range(0, 9) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(30, 80)) @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        in_t              opening [13];
        logic [CNT4_W-1:0] nsrc;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_NUM_SOURCES;
        cfg_data     = '0;
        live_sources = RST_NUM_SOURCES;
        // Runs under the reset configuration: empty events, the per-byte cap on both
        // sides of its length limit, saturation, and every kind of reseed.
        opening = '{
            pack_event(OP_SAMPLE, 3'd0, 32'd0, 24'd1),
            pack_event(OP_SEED, 3'd5, 32'd77, 24'd0),
            pack_event(OP_SAMPLE, 3'd2, 32'd500, 24'd0),
            pack_event(OP_SAMPLE, 3'd7, 32'hFFFFFFFF, 24'hFFFFFF),
            pack_event(OP_SAMPLE, 3'd7, 32'hFFFFFFFF, 24'hFFFFFF),
            pack_event(OP_SAMPLE, 3'd1, 32'd1000, 24'd40),
            pack_event(OP_SAMPLE, 3'd0, 32'h00100001, 24'h040000),
            pack_event(OP_SAMPLE, 3'd0, 32'h000FFFFF, 24'h03FFFF),
            pack_event(OP_SAMPLE, 3'd3, 32'd99, 24'd30),
            pack_event(OP_SAMPLE, 3'd3, 32'd5, 24'd1),
            pack_event(OP_SAMPLE, 3'd3, 32'd1, 24'd1),
            pack_event(OP_SEED, 3'd0, 32'd0, 24'hFFFFFF),
            pack_event(OP_SAMPLE, 3'd4, 32'h00100000, 24'd1)
        };
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (opening[i]) send_item(opening[i], 1'b0);
        s_valid <= 1'b0;

        run_phase(4'd8, 21'h1FFFFF, ENTROPY_CEIL, 4'd15, 120, 1'b0);
        run_phase(4'd1, 21'd0, 21'd0, 4'd0, 80, 1'b0);
        run_phase(4'd0, 21'd100, 21'd160, 4'd2, 30, 1'b0);
        run_phase(4'd15, ENTROPY_CEIL, ENTROPY_CEIL, 4'd8, 120, 1'b1);
        run_phase(4'd3, 21'd50, 21'd80, 4'd3, 150, 1'b0);
        for (int p = 0; p < 5; p++) begin
            nsrc = ($urandom_range(0, 9) == 0) ? CNT4_W'($urandom_range(9, 15))
                                               : CNT4_W'($urandom_range(1, 8));
            run_phase(nsrc, rand_threshold(), rand_threshold(),
                      CNT4_W'($urandom_range(0, 8)), 100, 1'b0);
        end
        run_phase(RST_NUM_SOURCES, RST_FAST_THRESHOLD, RST_SLOW_THRESHOLD,
                  RST_SOURCES_REQUIRED, 150, 1'b0);

        drain_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_entropy_accounting_reseed_control: clean");
        end else begin
            $display("tb_entropy_accounting_reseed_control: errors");
        end
        $finish;
    end

endmodule
